FILE: rtl/lzw_pkg.sv
// Shared types and constants of the LZW byte compressor.
package lzw_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int BYTE_W     = 8;
    localparam int OUT_CODE_W = 12;
    localparam int MAXC_W     = 12;

    // First learned phrase code; codes 1..256 are the single-byte roots
    localparam int FIRST_FREE = 257;

    // Reset value of the dictionary limit / end marker
    localparam logic [MAXC_W-1:0] MAX_CODE_RESET = 12'd4095;

    // Dictionary generation tag; tag zero marks a scrubbed slot
    localparam int EPOCH_BITS = 4;

    // Code that is sent out in an emit cycle
    typedef enum logic [1:0] {
        EMIT_MISS,
        EMIT_CLEAR,
        EMIT_MATCH,
        EMIT_END
    } t_emit_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      accept;      // input transaction taken this cycle
        logic      mem_rd;      // read hash slot at probe index
        logic      take_hit;    // match extends to the found code
        logic      learn;       // store new phrase, save miss code
        logic      probe_next;  // step to next hash slot
        logic      eval;        // resolve clear / end-of-stream bookkeeping
        logic      emit;        // load output register
        t_emit_sel emit_sel;
        logic      sweep;       // scrub one hash slot
        logic      sweep_done;  // scrub pass finished
    } t_ctrl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic match_zero;   // no current match
        logic hit;          // read slot holds the wanted phrase
        logic empty;        // read slot is free in this generation
        logic need_clear;   // next free code reached the limit
        logic pend_miss;    // a miss code waits to be sent
        logic pend_clear;   // a clear code waits to be sent
        logic eos;          // current item ends the stream
        logic out_free;     // output register can take a code
        logic sweep_last;   // scrub counter at the last slot
        logic sweep_pend;   // tag space wrapped, scrub needed
    } t_ctrl_stat;

endpackage

FILE: rtl/lzw_ctrl.sv
// Controller state machine: sequences probe, learn, clear, emit and scrub.
module lzw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lzw_pkg::t_ctrl_stat i_stat,
    output lzw_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EVAL,
        ST_EMIT_MISS,
        ST_EMIT_CLEAR,
        ST_EMIT_MATCH,
        ST_EMIT_END
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state s_done;

    // where to go once all codes of an item are out
    assign s_done = i_stat.sweep_pend ? ST_SWEEP : ST_IDLE;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.sweep_done = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.match_zero ? ST_EVAL : ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = ST_EVAL;
                end else if (i_stat.empty) begin
                    o_cmd.learn = 1'b1;
                    n_state     = ST_EVAL;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = ST_READ;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.pend_miss) begin
                    n_state = ST_EMIT_MISS;
                end else if (i_stat.need_clear) begin
                    n_state = ST_EMIT_CLEAR;
                end else if (i_stat.eos) begin
                    n_state = ST_EMIT_MATCH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_MISS: begin
                o_cmd.emit_sel = lzw_pkg::EMIT_MISS;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.pend_clear) begin
                        n_state = ST_EMIT_CLEAR;
                    end else if (i_stat.eos) begin
                        n_state = ST_EMIT_MATCH;
                    end else begin
                        n_state = s_done;
                    end
                end
            end
            ST_EMIT_CLEAR: begin
                o_cmd.emit_sel = lzw_pkg::EMIT_CLEAR;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.eos ? ST_EMIT_MATCH : s_done;
                end
            end
            ST_EMIT_MATCH: begin
                o_cmd.emit_sel = lzw_pkg::EMIT_MATCH;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_EMIT_END;
                end
            end
            ST_EMIT_END: begin
                o_cmd.emit_sel = lzw_pkg::EMIT_END;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = s_done;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register; reset starts with a scrub of the hash table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/lzw_dp.sv
// Datapath: hash table memory, match and code registers, output register.
module lzw_dp #(
    parameter int CODE_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lzw_pkg::t_ctrl_cmd                 i_cmd,
    output lzw_pkg::t_ctrl_stat                o_stat,
    input  logic [lzw_pkg::BYTE_W-1:0]         i_in_byte,
    input  logic                               i_in_eos,
    input  logic                               i_cfg_we,
    input  logic [lzw_pkg::MAXC_W-1:0]         i_cfg_wdata,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [lzw_pkg::OUT_CODE_W-1:0]     o_out_code,
    output logic                               o_out_last
);

    localparam int HASH_BITS = CODE_BITS + 1;
    localparam int KEY_W     = CODE_BITS + lzw_pkg::BYTE_W;
    localparam int TAG_W     = lzw_pkg::EPOCH_BITS;
    localparam int ENTRY_W   = TAG_W + KEY_W + CODE_BITS;
    localparam int DEPTH     = 1 << HASH_BITS;
    localparam int CMP_W     = (CODE_BITS > lzw_pkg::MAXC_W) ? CODE_BITS : lzw_pkg::MAXC_W;
    localparam int BYTE_SH   = HASH_BITS - lzw_pkg::BYTE_W;

    // hash slot: generation tag, phrase key, phrase code
    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [lzw_pkg::MAXC_W-1:0] r_max_code;
    logic [CODE_BITS-1:0]       r_match;
    logic [CODE_BITS-1:0]       r_next_free;
    logic [CODE_BITS-1:0]       r_miss_code;
    logic [CODE_BITS-1:0]       r_fin_code;
    logic [TAG_W-1:0]           r_epoch;
    logic                       r_dirty;
    logic                       r_sweep_pend;
    logic [HASH_BITS-1:0]       r_sweep_cnt;
    logic [HASH_BITS-1:0]       r_probe_idx;
    logic [lzw_pkg::BYTE_W-1:0] r_byte;
    logic                       r_eos;
    logic                       r_pend_miss;
    logic                       r_pend_clear;
    logic                       r_out_valid;
    logic [lzw_pkg::OUT_CODE_W-1:0] r_out_code;
    logic                       r_out_last;

    logic [TAG_W-1:0]     s_rd_tag;
    logic [KEY_W-1:0]     s_rd_key;
    logic [CODE_BITS-1:0] s_rd_code;
    logic [KEY_W-1:0]     s_key;
    logic [HASH_BITS-1:0] s_hash;
    logic                 s_need_clear;
    logic                 s_out_free;
    logic                 s_mem_we;
    logic [HASH_BITS-1:0] s_mem_waddr;
    logic [ENTRY_W-1:0]   s_mem_wdata;
    logic [CODE_BITS-1:0] s_byte_code;
    logic [lzw_pkg::OUT_CODE_W-1:0] s_emit_code;
    logic                 s_emit_last;

    assign {s_rd_tag, s_rd_key, s_rd_code} = r_rd_data;

    // phrase key of current match plus byte, and its home slot
    assign s_key  = {r_match, r_byte};
    assign s_hash = HASH_BITS'(r_match) ^ (HASH_BITS'(i_in_byte) << BYTE_SH);

    // root code of the latched byte
    assign s_byte_code = CODE_BITS'(r_byte) + CODE_BITS'(1);

    // limit check: configured limit or last code of the table
    assign s_need_clear = (CMP_W'(r_next_free) >= CMP_W'(r_max_code))
                       || (r_next_free >= {CODE_BITS{1'b1}});

    assign s_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat            = '0;
        o_stat.match_zero = (r_match == '0);
        o_stat.hit        = (s_rd_tag == r_epoch) && (s_rd_key == s_key);
        o_stat.empty      = (s_rd_tag != r_epoch);
        o_stat.need_clear = s_need_clear;
        o_stat.pend_miss  = r_pend_miss;
        o_stat.pend_clear = r_pend_clear;
        o_stat.eos        = r_eos;
        o_stat.out_free   = s_out_free;
        o_stat.sweep_last = &r_sweep_cnt;
        o_stat.sweep_pend = r_sweep_pend;
    end

    // single write port: scrub or learn
    always_comb begin
        s_mem_we    = i_cmd.sweep || i_cmd.learn;
        s_mem_waddr = i_cmd.sweep ? r_sweep_cnt : r_probe_idx;
        s_mem_wdata = i_cmd.sweep ? '0 : {r_epoch, s_key, r_next_free};
    end

    // hash table memory, registered read
    always_ff @(posedge i_clk) begin
        if (s_mem_we) begin
            r_mem[s_mem_waddr] <= s_mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[r_probe_idx];
        end
    end

    // item payload and probe pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte      <= i_in_byte;
            r_probe_idx <= s_hash;
        end else if (i_cmd.probe_next) begin
            r_probe_idx <= r_probe_idx + HASH_BITS'(1);
        end
        if (i_cmd.learn) begin
            r_miss_code <= r_match;
        end
        if (i_cmd.eval) begin
            r_fin_code <= r_match;
        end
    end

    // match, code allocation, dictionary generation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_code   <= lzw_pkg::MAX_CODE_RESET;
            r_match      <= '0;
            r_next_free  <= CODE_BITS'(lzw_pkg::FIRST_FREE);
            r_epoch      <= TAG_W'(1);
            r_dirty      <= 1'b0;
            r_sweep_pend <= 1'b0;
            r_sweep_cnt  <= '0;
            r_eos        <= 1'b0;
            r_pend_miss  <= 1'b0;
            r_pend_clear <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_code <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_eos        <= i_in_eos;
                r_pend_miss  <= 1'b0;
                r_pend_clear <= 1'b0;
                if (r_match == '0) begin
                    r_match <= CODE_BITS'(i_in_byte) + CODE_BITS'(1);
                end
            end
            if (i_cmd.take_hit) begin
                r_match <= s_rd_code;
            end
            if (i_cmd.learn) begin
                r_pend_miss <= 1'b1;
                r_match     <= s_byte_code;
                r_next_free <= r_next_free + CODE_BITS'(1);
                r_dirty     <= 1'b1;
            end
            if (i_cmd.eval) begin
                r_pend_clear <= s_need_clear;
                if (r_eos) begin
                    r_match <= '0;
                end
                // forget learned phrases by moving to a new generation
                if (s_need_clear || r_eos) begin
                    r_next_free <= CODE_BITS'(lzw_pkg::FIRST_FREE);
                    r_dirty     <= 1'b0;
                    if (r_dirty) begin
                        if (&r_epoch) begin
                            r_epoch      <= TAG_W'(1);
                            r_sweep_pend <= 1'b1;
                        end else begin
                            r_epoch <= r_epoch + TAG_W'(1);
                        end
                    end
                end
            end
            if (i_cmd.sweep) begin
                r_sweep_cnt <= r_sweep_cnt + HASH_BITS'(1);
            end
            if (i_cmd.sweep_done) begin
                r_sweep_pend <= 1'b0;
            end
        end
    end

    // code selection for the output register
    always_comb begin
        unique case (i_cmd.emit_sel)
            lzw_pkg::EMIT_MISS: begin
                s_emit_code = lzw_pkg::OUT_CODE_W'(r_miss_code);
                s_emit_last = !(r_pend_clear || r_eos);
            end
            lzw_pkg::EMIT_CLEAR: begin
                s_emit_code = '0;
                s_emit_last = !r_eos;
            end
            lzw_pkg::EMIT_MATCH: begin
                s_emit_code = lzw_pkg::OUT_CODE_W'(r_fin_code);
                s_emit_last = 1'b0;
            end
            lzw_pkg::EMIT_END: begin
                s_emit_code = lzw_pkg::OUT_CODE_W'(r_max_code);
                s_emit_last = 1'b1;
            end
            default: begin
                s_emit_code = '0;
                s_emit_last = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_code <= s_emit_code;
            r_out_last <= s_emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_code  = r_out_code;
    assign o_out_last  = r_out_last;

endmodule

FILE: rtl/lzw_byte_compressor_top.sv
// LZW byte compressor: one input byte per stream transaction, codes out per transaction.
// A byte that starts a match goes from accept straight to evaluate; other bytes run the hash
//   probe (accept, read, check, evaluate), with a read and check per extra linear probe step.
// Each emitted code passes through the output register; at most 4 codes per byte.
// Reset (synchronous, active low) scrubs the 2^(CODE_BITS+1)-slot hash table, one slot a
//   cycle, before the first byte; the same scrub reruns after every 15th clear of a used table.
module lzw_byte_compressor_top #(
    parameter int CODE_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_stream
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] code, [15:12] zero
    output logic        m_axis_tlast,   // last_of_run
    // max_code register
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata
);

    lzw_pkg::t_ctrl_cmd  s_cmd;
    lzw_pkg::t_ctrl_stat s_stat;
    logic [lzw_pkg::OUT_CODE_W-1:0] s_out_code;

    lzw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    lzw_dp #(
        .CODE_BITS (CODE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .i_in_byte   (s_axis_tdata),
        .i_in_eos    (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_code  (s_out_code),
        .o_out_last  (m_axis_tlast)
    );

    // pad code to whole bytes
    assign m_axis_tdata = {4'b0000, s_out_code};

endmodule
